// ===== rtl/lkd_pkg.sv =====
package lkd_pkg;

	localparam int unsigned WORD_W    = 32;
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned SHIFT_W   = 5;
	localparam int unsigned MODE_W    = 3;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 64;
	localparam int unsigned OFFSET_W  = 32;

	localparam logic [BYTE_W-1:0] FEEDBACK_START = 8'h59;

	localparam logic CMD_DECRYPT = 1'b0;
	localparam logic CMD_SEEK    = 1'b1;

	typedef enum logic [MODE_W-1:0] {
		MODE_NONE      = 3'd0,
		MODE_SINGLE    = 3'd1,
		MODE_FEEDBACK  = 3'd2,
		MODE_DUAL      = 3'd3,
		MODE_DUAL_EVEN = 3'd4
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE      = 3'd0,
		REG_PRI_MUL   = 3'd1,
		REG_PRI_INC   = 3'd2,
		REG_PRI_SHIFT = 3'd3,
		REG_SEC_MUL   = 3'd4,
		REG_SEC_INC   = 3'd5,
		REG_SEC_SHIFT = 3'd6,
		REG_SEEDS     = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [MODE_W-1:0]     mode;
		logic [WORD_W-1:0]     pri_mul;
		logic [WORD_W-1:0]     pri_inc;
		logic [SHIFT_W-1:0]    pri_shift;
		logic [WORD_W-1:0]     sec_mul;
		logic [WORD_W-1:0]     sec_inc;
		logic [SHIFT_W-1:0]    sec_shift;
		logic [CFG_DATA_W-1:0] seeds;
	} cfg_t;

	typedef struct packed {
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
		logic [WORD_W-1:0] c;
	} mac_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PRI,
		ST_SEC,
		ST_JAI,
		ST_JAM,
		ST_JINC,
		ST_JMUL,
		ST_JFIN,
		ST_OUT
	} state_t;

endpackage

// ===== rtl/lkd_cfg.sv =====
module lkd_cfg
	import lkd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode      <= MODE_NONE;
			cfg_q.pri_mul   <= 32'd1;
			cfg_q.pri_inc   <= '0;
			cfg_q.pri_shift <= 5'd24;
			cfg_q.sec_mul   <= 32'd1;
			cfg_q.sec_inc   <= '0;
			cfg_q.sec_shift <= 5'd24;
			cfg_q.seeds     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_MODE:      cfg_q.mode      <= cfg_data[MODE_W-1:0];
				REG_PRI_MUL:   cfg_q.pri_mul   <= cfg_data[WORD_W-1:0];
				REG_PRI_INC:   cfg_q.pri_inc   <= cfg_data[WORD_W-1:0];
				REG_PRI_SHIFT: cfg_q.pri_shift <= cfg_data[SHIFT_W-1:0];
				REG_SEC_MUL:   cfg_q.sec_mul   <= cfg_data[WORD_W-1:0];
				REG_SEC_INC:   cfg_q.sec_inc   <= cfg_data[WORD_W-1:0];
				REG_SEC_SHIFT: cfg_q.sec_shift <= cfg_data[SHIFT_W-1:0];
				REG_SEEDS:     cfg_q.seeds     <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/lkd_mac.sv =====
module lkd_mac
	import lkd_pkg::*;
(
	input  mac_op_t           op,
	output logic [WORD_W-1:0] y
);

	logic [2*WORD_W-1:0] prod;

	assign prod = op.a * op.b;
	assign y    = prod[WORD_W-1:0] + op.c;

endmodule

// ===== rtl/lcg_keystream_byte_decryptor_unit.sv =====
// byte stream decryptor keyed by one or two 32-bit linear congruential generators
// input stream: s_tdata carries the ciphertext byte and the seek offset, s_tuser
// says whether the transfer is a decrypt or a seek and flags the first byte of a buffer
// output stream: one result per input transfer, plaintext byte plus seek error flag
// config channel: register index and 64-bit data, always ready, write only while idle
// one shared 32x32 multiply-add unit does every generator step under a sequencer
// a decrypt steps through ST_PRI, then ST_SEC with two generators, then ST_OUT;
// pass-through bytes go straight to ST_OUT; the next transfer is taken once the result is registered
// a seek runs square-and-multiply per generator: ST_JAI, ST_JAM, ST_JINC and ST_JMUL for
// each set offset bit and ST_JINC, ST_JMUL for each clear bit up to the highest set one,
// plus one final ST_JFIN step (both generators in dual modes)
// reset clears the generator states, loads 0x59 as feedback byte and even parity
// a stalled receiver holds the output register; one more item may be taken and
// finished meanwhile, then the sequencer waits for the output register to free up
module lcg_keystream_byte_decryptor_unit
	import lkd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [39:0]           s_tdata,  // data_in, seek_offset
	input  logic [1:0]            s_tuser,  // command, buffer_start
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [7:0]            m_tdata,  // data_out
	output logic [0:0]            m_tuser,  // seek_error
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t cfg;
	mac_op_t mac_op;
	logic [WORD_W-1:0] mac_y;

	state_t state_q, state_d;
	logic [WORD_W-1:0] st_p_q, st_s_q;
	logic [BYTE_W-1:0] prev_q;
	logic odd_q, gen_q, dual_q, out_valid_q;
	logic [WORD_W-1:0] acc_mul_q, acc_inc_q, jm_q, ji_q;
	logic [OFFSET_W-2:0] off_q, off_save_q;
	logic [BYTE_W-1:0] res_data_q, out_data_q;
	logic res_err_q, out_err_q;

	logic accept_in, cmd, bstart, odd_eff, single_now, dual_now, jump_mode, out_free;
	logic [BYTE_W-1:0] din, prev_eff, key_p, key_s, dec_byte;
	logic [OFFSET_W-1:0] offset;
	logic [WORD_W-1:0] seed_p, seed_s, sh_p, sh_s;

	lkd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lkd_mac u_mac (
		.op (mac_op),
		.y  (mac_y)
	);

	function automatic state_t jump_entry(input logic [OFFSET_W-2:0] off);
		state_t s;
		if (off == '0) begin
			s = ST_JFIN;
		end else if (off[0]) begin
			s = ST_JAI;
		end else begin
			s = ST_JINC;
		end
		return s;
	endfunction

	assign s_tready  = (state_q == ST_IDLE);
	assign accept_in = s_tvalid && s_tready;
	assign cmd       = s_tuser[0];
	assign bstart    = s_tuser[1];
	assign din       = s_tdata[7:0];
	assign offset    = s_tdata[39:8];
	assign seed_p    = cfg.seeds[WORD_W-1:0];
	assign seed_s    = cfg.seeds[CFG_DATA_W-1:WORD_W];
	assign out_free  = !out_valid_q || m_tready;

	assign prev_eff   = bstart ? FEEDBACK_START : prev_q;
	assign odd_eff    = bstart ? 1'b0 : odd_q;
	assign sh_p       = st_p_q >> cfg.pri_shift;
	assign sh_s       = st_s_q >> cfg.sec_shift;
	assign key_p      = sh_p[BYTE_W-1:0];
	assign key_s      = sh_s[BYTE_W-1:0];
	assign single_now = (cfg.mode == MODE_SINGLE) || (cfg.mode == MODE_FEEDBACK);
	assign dual_now   = (cfg.mode == MODE_DUAL) || (cfg.mode == MODE_DUAL_EVEN && !odd_eff);
	assign jump_mode  = (cfg.mode == MODE_SINGLE) || (cfg.mode == MODE_DUAL)
		|| (cfg.mode == MODE_DUAL_EVEN);
	assign dec_byte   = din ^ (single_now ? key_p : '0)
		^ ((cfg.mode == MODE_FEEDBACK) ? prev_eff : '0)
		^ (dual_now ? (key_p ^ key_s) : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		mac_op  = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept_in) begin
					if (cmd == CMD_DECRYPT) begin
						state_d = (single_now || dual_now) ? ST_PRI : ST_OUT;
					end else if (jump_mode && !offset[OFFSET_W-1]) begin
						state_d = jump_entry(offset[OFFSET_W-2:0]);
					end else begin
						state_d = ST_OUT;
					end
				end
			end
			ST_PRI: begin
				mac_op  = '{a: st_p_q, b: cfg.pri_mul, c: cfg.pri_inc};
				state_d = dual_q ? ST_SEC : ST_OUT;
			end
			ST_SEC: begin
				mac_op  = '{a: st_s_q, b: cfg.sec_mul, c: cfg.sec_inc};
				state_d = ST_OUT;
			end
			ST_JAI: begin
				mac_op  = '{a: ji_q, b: acc_mul_q, c: acc_inc_q};
				state_d = ST_JAM;
			end
			ST_JAM: begin
				mac_op  = '{a: acc_mul_q, b: jm_q, c: '0};
				state_d = ST_JINC;
			end
			ST_JINC: begin
				mac_op  = '{a: ji_q, b: jm_q, c: ji_q};
				state_d = ST_JMUL;
			end
			ST_JMUL: begin
				mac_op  = '{a: jm_q, b: jm_q, c: '0};
				state_d = jump_entry(off_q >> 1);
			end
			ST_JFIN: begin
				mac_op  = '{a: acc_mul_q, b: (gen_q ? seed_s : seed_p), c: acc_inc_q};
				state_d = (!gen_q && dual_q) ? jump_entry(off_save_q) : ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// architectural and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_p_q      <= '0;
			st_s_q      <= '0;
			prev_q      <= FEEDBACK_START;
			odd_q       <= 1'b0;
			gen_q       <= 1'b0;
			dual_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (m_tvalid && m_tready && state_q != ST_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept_in) begin
						gen_q <= 1'b0;
						if (cmd == CMD_DECRYPT) begin
							prev_q <= din;
							odd_q  <= !odd_eff;
							dual_q <= dual_now;
						end else begin
							dual_q <= (cfg.mode == MODE_DUAL) || (cfg.mode == MODE_DUAL_EVEN);
							if (jump_mode && offset[OFFSET_W-1]) begin
								st_p_q <= seed_p;
								if (cfg.mode != MODE_SINGLE) begin
									st_s_q <= seed_s;
								end
							end
						end
					end
				end
				ST_PRI: st_p_q <= mac_y;
				ST_SEC: st_s_q <= mac_y;
				ST_JFIN: begin
					if (gen_q) begin
						st_s_q <= mac_y;
					end else begin
						st_p_q <= mac_y;
					end
					if (!gen_q && dual_q) begin
						gen_q <= 1'b1;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// square-and-multiply working registers and result payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept_in) begin
					res_err_q  <= (cmd == CMD_SEEK) && (cfg.mode == MODE_FEEDBACK);
					res_data_q <= (cmd == CMD_SEEK) ? '0 : dec_byte;
					acc_mul_q  <= 32'd1;
					acc_inc_q  <= '0;
					jm_q       <= cfg.pri_mul;
					ji_q       <= cfg.pri_inc;
					off_q      <= offset[OFFSET_W-2:0];
					off_save_q <= offset[OFFSET_W-2:0];
				end
			end
			ST_JAI:  acc_inc_q <= mac_y;
			ST_JAM:  acc_mul_q <= mac_y;
			ST_JINC: ji_q      <= mac_y;
			ST_JMUL: begin
				jm_q  <= mac_y;
				off_q <= off_q >> 1;
			end
			ST_JFIN: begin
				if (!gen_q && dual_q) begin
					acc_mul_q <= 32'd1;
					acc_inc_q <= '0;
					jm_q      <= cfg.sec_mul;
					ji_q      <= cfg.sec_inc;
					off_q     <= off_save_q;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					out_data_q <= res_data_q;
					out_err_q  <= res_err_q;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = out_data_q;
	assign m_tuser[0] = out_err_q;

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken again right after a transfer");

	a_error_only_feedback: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> cfg.mode == MODE_FEEDBACK)
		else $error("seek error flagged outside feedback mode");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT && out_valid_q && !m_tready |=> state_q == ST_OUT)
		else $error("result loaded over a pending output");

endmodule

// ===== tb/sv/lcg_keystream_byte_decryptor_unit_tb.sv =====
`timescale 1ns / 1ps

module lcg_keystream_byte_decryptor_unit_tb
	import lkd_pkg::*;
;

	localparam logic [MODE_W-1:0] MODE_RSVD_LO = 3'd5;
	localparam logic [MODE_W-1:0] MODE_RSVD_HI = 3'd7;
	localparam int WD_LIMIT = 2000;
	localparam int RAND_PHASES = 10;
	localparam int ITEMS_PER_PHASE = 110;

	typedef struct {
		logic        cmd;
		logic [7:0]  data;
		logic        start;
		logic [31:0] offset;
	} xfer_t;

	typedef struct {
		logic [7:0] plain;
		logic       err;
	} outcome_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [39:0]           s_tdata = '0;
	logic [1:0]            s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [7:0]            m_tdata;
	logic [0:0]            m_tuser;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// register shadow
	logic [MODE_W-1:0]     k_mode = MODE_NONE;
	logic [31:0]           k_pmul = 32'd1;
	logic [31:0]           k_pinc = '0;
	logic [4:0]            k_psh = 5'd24;
	logic [31:0]           k_smul = 32'd1;
	logic [31:0]           k_sinc = '0;
	logic [4:0]            k_ssh = 5'd24;
	logic [63:0]           k_seeds = '0;

	// generator and buffer state
	logic [31:0]           pri_st = '0;
	logic [31:0]           sec_st = '0;
	logic [7:0]            prev_ct = FEEDBACK_START;
	logic                  odd_pos = 1'b0;

	xfer_t    pending_q[$];
	outcome_t plain_q[$];
	xfer_t    on_bus;
	outcome_t want;

	int n_queued = 0;
	int n_in = 0;
	int n_out = 0;
	int n_seek = 0;
	int n_cfg = 0;
	int err_cnt = 0;
	int gap_left = 0;
	int burst_left = 1;
	int rdy_left = 0;
	logic rdy_phase = 1'b0;
	int idle_cycles = 0;
	int buf_left = 0;

	lcg_keystream_byte_decryptor_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic logic [31:0] jump_ahead(input logic [31:0] seed, input logic [31:0] mul,
			input logic [31:0] inc, input logic [31:0] count);
		logic [31:0] acc_m;
		logic [31:0] acc_i;
		logic [31:0] m;
		logic [31:0] c;
		acc_m = 32'd1;
		acc_i = '0;
		m = mul;
		c = inc;
		if (count[31])
			return seed;
		for (int i = 0; i < 31; i++) begin
			if (count[i]) begin
				acc_i = acc_i + c * acc_m;
				acc_m = acc_m * m;
			end
			c = c + c * m;
			m = m * m;
		end
		return acc_m * seed + acc_i;
	endfunction

	function automatic logic [7:0] key_of(input logic [31:0] s, input logic [4:0] sh);
		logic [31:0] t;
		t = s >> sh;
		return t[7:0];
	endfunction

	task automatic decrypt_step(input xfer_t it);
		outcome_t r;
		logic dual;
		r.plain = '0;
		r.err = 1'b0;
		if (it.cmd == CMD_SEEK) begin
			n_seek++;
			if (k_mode == MODE_SINGLE) begin
				pri_st = jump_ahead(k_seeds[31:0], k_pmul, k_pinc, it.offset);
			end else if (k_mode == MODE_FEEDBACK) begin
				r.err = 1'b1;
			end else if (k_mode == MODE_DUAL || k_mode == MODE_DUAL_EVEN) begin
				pri_st = jump_ahead(k_seeds[31:0], k_pmul, k_pinc, it.offset);
				sec_st = jump_ahead(k_seeds[63:32], k_smul, k_sinc, it.offset);
			end
		end else begin
			if (it.start) begin
				prev_ct = FEEDBACK_START;
				odd_pos = 1'b0;
			end
			r.plain = it.data;
			if (k_mode == MODE_SINGLE || k_mode == MODE_FEEDBACK) begin
				r.plain ^= key_of(pri_st, k_psh);
				if (k_mode == MODE_FEEDBACK)
					r.plain ^= prev_ct;
				pri_st = pri_st * k_pmul + k_pinc;
			end else begin
				dual = (k_mode == MODE_DUAL) || (k_mode == MODE_DUAL_EVEN && !odd_pos);
				if (dual) begin
					r.plain ^= key_of(pri_st, k_psh) ^ key_of(sec_st, k_ssh);
					pri_st = pri_st * k_pmul + k_pinc;
					sec_st = sec_st * k_smul + k_sinc;
				end
			end
			prev_ct = it.data;
			odd_pos = ~odd_pos;
		end
		plain_q.push_back(r);
	endtask

	// input side: bursts with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				decrypt_step(on_bus);
				n_in++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left != 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pending_q.size() != 0) begin
					on_bus = pending_q.pop_front();
					s_tdata <= {on_bus.offset, on_bus.data};
					s_tuser <= {on_bus.start, on_bus.cmd};
					s_tvalid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left = ($urandom_range(0, 5) == 0) ? 80 : $urandom_range(1, 20);
						gap_left = $urandom_range(0, 10);
					end else begin
						burst_left--;
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// output side: check against the oldest expected byte, stall in stretches
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				n_out++;
				if (plain_q.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("unexpected result: data_out=%h seek_error=%b", m_tdata, m_tuser[0]);
				end else begin
					want = plain_q.pop_front();
					if (m_tdata !== want.plain || m_tuser[0] !== want.err) begin
						err_cnt++;
						if (err_cnt <= 10)
							$display("mismatch at result %0d: data_out exp %h got %h, seek_error exp %b got %b",
								n_out, want.plain, m_tdata, want.err, m_tuser[0]);
					end
				end
			end
			if (rdy_left == 0) begin
				rdy_phase = !rdy_phase;
				if (rdy_phase)
					rdy_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 30);
				else
					rdy_left = $urandom_range(1, 12);
			end
			rdy_left--;
			m_tready <= rdy_phase;
		end
	end

	// cycles with no transfer on any channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WD_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", WD_LIMIT);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	task automatic write_reg(input cfg_reg_t idx, input logic [63:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		n_cfg++;
		case (idx)
			REG_MODE:      k_mode = val[MODE_W-1:0];
			REG_PRI_MUL:   k_pmul = val[31:0];
			REG_PRI_INC:   k_pinc = val[31:0];
			REG_PRI_SHIFT: k_psh = val[4:0];
			REG_SEC_MUL:   k_smul = val[31:0];
			REG_SEC_INC:   k_sinc = val[31:0];
			REG_SEC_SHIFT: k_ssh = val[4:0];
			REG_SEEDS:     k_seeds = val;
			default: ;
		endcase
	endtask

	task automatic set_all(input logic [MODE_W-1:0] m, input logic [31:0] pm, input logic [31:0] pi,
			input logic [4:0] ps, input logic [31:0] sm, input logic [31:0] si, input logic [4:0] ss,
			input logic [63:0] seeds);
		write_reg(REG_MODE, {61'd0, m});
		write_reg(REG_PRI_MUL, {32'd0, pm});
		write_reg(REG_PRI_INC, {32'd0, pi});
		write_reg(REG_PRI_SHIFT, {59'd0, ps});
		write_reg(REG_SEC_MUL, {32'd0, sm});
		write_reg(REG_SEC_INC, {32'd0, si});
		write_reg(REG_SEC_SHIFT, {59'd0, ss});
		write_reg(REG_SEEDS, seeds);
	endtask

	task automatic wait_idle();
		do @(posedge clk); while (n_in != n_queued || plain_q.size() != 0);
	endtask

	task automatic push_decrypt(input logic [7:0] d, input logic st);
		xfer_t it;
		it.cmd = CMD_DECRYPT;
		it.data = d;
		it.start = st;
		it.offset = $urandom();
		pending_q.push_back(it);
		n_queued++;
	endtask

	task automatic push_seek(input logic [31:0] ofs);
		xfer_t it;
		it.cmd = CMD_SEEK;
		it.data = 8'($urandom_range(0, 255));
		it.start = 1'($urandom_range(0, 1));
		it.offset = ofs;
		pending_q.push_back(it);
		n_queued++;
	endtask

	// mostly whole buffers of random bytes, with seeks dropped in
	task automatic push_random();
		logic [31:0] ofs;
		if ($urandom_range(0, 99) < 12) begin
			case ($urandom_range(0, 3))
				0: ofs = $urandom();
				1: ofs = $urandom() | 32'h8000_0000;
				2: ofs = $urandom_range(0, 300);
				default: ofs = $urandom() >> $urandom_range(0, 31);
			endcase
			push_seek(ofs);
		end else if (buf_left == 0 || $urandom_range(0, 49) == 0) begin
			buf_left = $urandom_range(1, 24);
			push_decrypt(8'($urandom_range(0, 255)), 1'b1);
			buf_left--;
		end else begin
			push_decrypt(8'($urandom_range(0, 255)), 1'b0);
			buf_left--;
		end
	endtask

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'd1;
			2: return 32'hFFFF_FFFF;
			3: return $urandom() | 32'd1;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [4:0] pick_shift();
		case ($urandom_range(0, 3))
			0: return 5'd0;
			1: return 5'd31;
			default: return 5'($urandom_range(0, 31));
		endcase
	endfunction

	initial begin
		logic [MODE_W-1:0] rand_modes[RAND_PHASES];
		rand_modes = '{MODE_SINGLE, MODE_DUAL, MODE_FEEDBACK, MODE_DUAL_EVEN, MODE_NONE,
			MODE_SINGLE, MODE_DUAL, MODE_DUAL_EVEN, MODE_FEEDBACK, MODE_RSVD_HI};

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: pass-through
		push_decrypt(8'h00, 1'b1);
		push_decrypt(8'hFF, 1'b0);
		push_seek(32'd0);
		push_seek(32'hFFFF_FFFF);
		wait_idle();

		// single generator, seed offset and largest offset
		set_all(MODE_SINGLE, 32'd1664525, 32'd1013904223, 5'd24, 32'd22695477, 32'd1, 5'd16,
			{$urandom(), $urandom()});
		push_seek(32'h8000_0000);
		push_decrypt(8'hFF, 1'b1);
		push_decrypt(8'h00, 1'b0);
		push_seek(32'h7FFF_FFFF);
		push_decrypt(8'hA5, 1'b0);
		push_seek(32'd0);
		push_decrypt(8'h3C, 1'b0);
		wait_idle();

		// feedback, seek flags an error
		write_reg(REG_MODE, {61'd0, MODE_FEEDBACK});
		push_decrypt(8'h12, 1'b1);
		push_decrypt(8'h34, 1'b0);
		push_seek(32'd7);
		push_decrypt(8'h56, 1'b0);
		push_decrypt(8'h78, 1'b1);
		wait_idle();

		write_reg(REG_MODE, {61'd0, MODE_DUAL});
		write_reg(REG_PRI_SHIFT, 64'd0);
		write_reg(REG_SEC_SHIFT, 64'd31);
		push_seek(32'd3);
		push_decrypt(8'hFF, 1'b1);
		push_decrypt(8'h00, 1'b0);
		wait_idle();

		// even-only, seek in the middle of a buffer keeps parity
		write_reg(REG_MODE, {61'd0, MODE_DUAL_EVEN});
		push_seek(32'd1);
		push_decrypt(8'h11, 1'b1);
		push_decrypt(8'h22, 1'b0);
		push_seek(32'd2);
		push_decrypt(8'h33, 1'b0);
		push_decrypt(8'h44, 1'b0);
		wait_idle();

		write_reg(REG_MODE, {61'd0, MODE_RSVD_LO});
		push_decrypt(8'h55, 1'b0);
		push_seek(32'd9);
		wait_idle();

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			if (ph == 0)
				set_all(rand_modes[ph], '0, '0, 5'd0, '0, '0, 5'd0, '0);
			else if (ph == 1)
				set_all(rand_modes[ph], '1, '1, 5'd31, '1, '1, 5'd31, '1);
			else
				set_all(rand_modes[ph], pick_word(), pick_word(), pick_shift(), pick_word(),
					pick_word(), pick_shift(), {$urandom(), $urandom()});
			buf_left = 0;
			repeat (ITEMS_PER_PHASE) push_random();
			wait_idle();
		end

		repeat (300) @(posedge clk);
		if (plain_q.size() != 0) begin
			err_cnt += plain_q.size();
			$display("%0d expected results never arrived", plain_q.size());
		end
		$display("covered %0d input transfers (%0d seeks), %0d results, %0d register writes",
			n_in, n_seek, n_out, n_cfg);
		$display("modes: pass-through, single, feedback, dual, dual even-only and reserved codes");
		if (err_cnt == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
